@@ hw/rtl/subband_synthesis_bank_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the subband synthesis bank.
// Concurrent assertion wrappers that drop out in synthesis.
// ----------------------------------------------------------------------------
`ifndef SUBBAND_SYNTHESIS_BANK_CORE_MACROS_SVH
`define SUBBAND_SYNTHESIS_BANK_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SSB_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SSB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define SSB_ASSERT_IMPL(label, clk, rst_n, prop)
`define SSB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/ssb_pkg.sv @@
// ----------------------------------------------------------------------------
// Subband synthesis bank package
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ssb_pkg;
    localparam int BANDS_DEF = 16;
    localparam int TAPS_DEF  = 256;
    localparam int BAND_W    = 6;
    localparam int TAP_W     = 10;
    localparam int COEF_W    = 18;
    localparam int SAMP_W    = 24;
    localparam int ACC_W     = 64;
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic clear_pend;
        logic shift_hist;
        logic clear_acc;
        logic mac_en;
        logic load_out;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;
endpackage

@@ hw/rtl/subband_synthesis_bank_core.sv @@
// ----------------------------------------------------------------------------
// Subband synthesis bank core
// Polyphase synthesis filter bank with one multiply-accumulate per cycle during a sweep.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake
//  in        input      i_in_valid / o_in_ready
//  cfg       input      i_cfg_valid / o_cfg_ready
//  out       output     o_out_valid / i_out_ready
//
// Coefficient writes and samples other than the last band's are accepted while idle.
// The last band's sample starts a run: the history of every band is written, then
// each of the BANDS outputs is computed by one sweep on the one multiplier.
// Input is held off during a run; a stalled output holds the sweep.
// Reset clears pending values; history reads as zero until written; coefficients
// are undefined.
module subband_synthesis_bank_core #(
    parameter int BANDS = ssb_pkg::BANDS_DEF,
    parameter int TAPS  = ssb_pkg::TAPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [ssb_pkg::BAND_W-1:0]         i_band_index,
    input  logic [ssb_pkg::TAP_W-1:0]          i_tap_index,
    input  logic signed [ssb_pkg::COEF_W-1:0]  i_coefficient,
    input  logic signed [ssb_pkg::SAMP_W-1:0]  i_subband_sample,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ssb_pkg::SAMP_W-1:0]  o_output_sample,
    output logic                               o_last_of_run
);
    import ssb_pkg::*;
`include "subband_synthesis_bank_core_macros.svh"

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HD = (TAPS + BANDS - 1) / BANDS;
    localparam int HW = (HD > 1) ? $clog2(HD) : 1;

    logic          r_mode;
    logic          w_busy, w_acc, w_band_ok, w_start, w_tap_ok;
    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [BW-1:0] w_n, w_m;
    logic [HW-1:0] w_k;

    assign o_in_ready  = !w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_band_ok = (32'(i_band_index) < 32'(BANDS));
    assign w_start   = w_acc && (i_kind == KIND_SAMPLE) && w_band_ok
                       && (32'(i_band_index) == 32'(BANDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b1;
        else if (i_cfg_valid) r_mode <= i_cfg_data;
    end

    ssb_ctrl #(.BANDS(BANDS), .TAPS(TAPS)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(w_start), .i_sts(w_sts), .o_busy(w_busy),
        .o_cmd(w_cmd), .o_n(w_n), .o_m(w_m), .o_k(w_k), .o_tap_ok(w_tap_ok)
    );

    ssb_datapath #(.BANDS(BANDS), .TAPS(TAPS)) u_dp (
        .i_clk, .i_rst_n,
        .i_coef_we(w_acc && (i_kind == KIND_COEF) && w_band_ok
                   && (32'(i_tap_index) < 32'(TAPS))),
        .i_coef_band(i_band_index[BW-1:0]), .i_coef_tap(i_tap_index[TW-1:0]),
        .i_coef(i_coefficient),
        .i_pend_we(w_acc && (i_kind == KIND_SAMPLE) && w_band_ok),
        .i_pend_band(i_band_index[BW-1:0]), .i_pend_val(i_subband_sample),
        .i_mode(r_mode), .i_cmd(w_cmd), .i_n(w_n), .i_m(w_m), .i_k(w_k),
        .i_tap_ok(w_tap_ok), .o_sts(w_sts), .o_valid(o_out_valid),
        .i_ready(i_out_ready), .o_sample(o_output_sample), .o_last(o_last_of_run)
    );

    `SSB_ASSERT_NEVER(a_no_in_busy, i_clk, i_rst_n, w_busy && o_in_ready)
    `SSB_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_cmd.load_out |-> !w_sts.out_full)
    `SSB_ASSERT_IMPL(a_start_busy, i_clk, i_rst_n, w_start |=> w_busy)
endmodule

@@ hw/rtl/ssb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Subband synthesis bank controller
// Sequences history shift, the MAC sweep per output and the result handoff.
// ----------------------------------------------------------------------------
module ssb_ctrl #(
    parameter int BANDS = ssb_pkg::BANDS_DEF,
    parameter int TAPS  = ssb_pkg::TAPS_DEF,
    parameter int BW    = (BANDS > 1) ? $clog2(BANDS) : 1,
    parameter int HD    = (TAPS + BANDS - 1) / BANDS,
    parameter int HW    = (HD > 1) ? $clog2(HD) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ssb_pkg::t_dp_sts   i_sts,
    output logic               o_busy,
    output ssb_pkg::t_dp_cmd   o_cmd,
    output logic [BW-1:0]      o_n,
    output logic [BW-1:0]      o_m,
    output logic [HW-1:0]      o_k,
    output logic               o_tap_ok
);
    import ssb_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_MAC, S_DRAIN, S_OUT} t_state;

    t_state        r_state;
    logic [BW-1:0] r_n, r_m;
    logic [HW-1:0] r_k;
    logic [1:0]    r_drain;
    logic [31:0]   w_tap;

    assign w_tap    = 32'(r_n) + 32'(r_k) * 32'(BANDS);
    assign o_tap_ok = (w_tap < 32'(TAPS));
    assign o_n = r_n;
    assign o_m = r_m;
    assign o_k = r_k;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.clear_pend = (r_state == S_SHIFT);
        o_cmd.shift_hist = (r_state == S_SHIFT);
        o_cmd.clear_acc  = (r_state == S_SHIFT) || (r_state == S_OUT && !i_sts.out_full);
        o_cmd.mac_en     = (r_state == S_MAC);
        o_cmd.load_out   = (r_state == S_OUT) && !i_sts.out_full;
        o_cmd.out_last   = (r_n == BW'(BANDS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= '0; r_m <= '0; r_k <= '0; r_drain <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m <= '0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_m == BW'(BANDS - 1)) begin
                        r_n <= '0; r_m <= '0; r_k <= '0;
                        r_state <= S_MAC;
                    end else r_m <= r_m + 1'b1;
                end
                S_MAC: begin
                    if (r_k == HW'(HD - 1)) begin
                        r_k <= '0;
                        if (r_m == BW'(BANDS - 1)) begin
                            r_m <= '0;
                            r_drain <= '0;
                            r_state <= S_DRAIN;
                        end else r_m <= r_m + 1'b1;
                    end else r_k <= r_k + 1'b1;
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 1'b1;
                    if (r_drain == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_sts.out_full) begin
                        if (r_n == BW'(BANDS - 1)) r_state <= S_IDLE;
                        else begin
                            r_n <= r_n + 1'b1;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/ssb_datapath.sv @@
// ----------------------------------------------------------------------------
// Subband synthesis bank datapath
// Coefficient and history memories, pending values, MAC pipe and output stage.
// ----------------------------------------------------------------------------
module ssb_datapath #(
    parameter int BANDS = ssb_pkg::BANDS_DEF,
    parameter int TAPS  = ssb_pkg::TAPS_DEF,
    parameter int BW    = (BANDS > 1) ? $clog2(BANDS) : 1,
    parameter int TW    = (TAPS > 1) ? $clog2(TAPS) : 1,
    parameter int HD    = (TAPS + BANDS - 1) / BANDS,
    parameter int HW    = (HD > 1) ? $clog2(HD) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_coef_we,
    input  logic [BW-1:0]                      i_coef_band,
    input  logic [TW-1:0]                      i_coef_tap,
    input  logic signed [ssb_pkg::COEF_W-1:0]  i_coef,
    input  logic                               i_pend_we,
    input  logic [BW-1:0]                      i_pend_band,
    input  logic signed [ssb_pkg::SAMP_W-1:0]  i_pend_val,
    input  logic                               i_mode,
    input  ssb_pkg::t_dp_cmd                   i_cmd,
    input  logic [BW-1:0]                      i_n,
    input  logic [BW-1:0]                      i_m,
    input  logic [HW-1:0]                      i_k,
    input  logic                               i_tap_ok,
    output ssb_pkg::t_dp_sts                   o_sts,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ssb_pkg::SAMP_W-1:0]  o_sample,
    output logic                               o_last
);
    import ssb_pkg::*;

    localparam int NH  = BANDS * HD;
    localparam int CAW = (BANDS * TAPS > 1) ? $clog2(BANDS * TAPS) : 1;
    localparam int HAW = (NH > 1) ? $clog2(NH) : 1;

    // Each band's history is a ring addressed from a shared head slot; entries
    // at or beyond the fill count have never been written and count as zero.
    logic signed [COEF_W-1:0] r_coef_mem [BANDS*TAPS];
    logic signed [SAMP_W-1:0] r_hist [NH];
    logic signed [SAMP_W-1:0] r_pend [BANDS];
    logic [HW-1:0]            r_head;
    logic [HW:0]              r_fill;
    logic signed [COEF_W-1:0] r_c;
    logic signed [SAMP_W-1:0] r_h;
    logic                     r_v1, r_v2;
    logic signed [COEF_W+SAMP_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_v, r_out_last;
    logic signed [SAMP_W-1:0] r_out;
    logic signed [ACC_W-1:0]  n_rnd;
    logic signed [SAMP_W-1:0] n_res;
    logic [HW:0]              w_slot_sum;
    logic [HW-1:0]            w_slot, w_new_head;
    logic                     w_hist_ok;
    logic [31:0]              w_caddr, w_haddr, w_waddr, w_saddr;

    assign w_slot_sum = {1'b0, r_head} + {1'b0, i_k};
    assign w_slot     = (w_slot_sum >= (HW+1)'(HD)) ? HW'(w_slot_sum - (HW+1)'(HD))
                                                    : w_slot_sum[HW-1:0];
    assign w_new_head = (r_head == '0) ? HW'(HD - 1) : r_head - 1'b1;
    assign w_hist_ok  = ({1'b0, i_k} < r_fill);

    assign w_caddr = 32'(i_m) * 32'(TAPS) + 32'(i_n) + 32'(i_k) * 32'(BANDS);
    assign w_haddr = 32'(i_m) * 32'(HD) + 32'(w_slot);
    assign w_saddr = 32'(i_m) * 32'(HD) + 32'(w_new_head);
    assign w_waddr = 32'(i_coef_band) * 32'(TAPS) + 32'(i_coef_tap);

    always_ff @(posedge i_clk) begin
        if (i_coef_we)
            r_coef_mem[w_waddr[CAW-1:0]] <= i_coef;
        r_c <= r_coef_mem[w_caddr[CAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_hist)
            r_hist[w_saddr[HAW-1:0]] <= r_pend[i_m];
        r_h <= r_hist[w_haddr[HAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BANDS; i++) r_pend[i] <= '0;
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear_pend) begin
            r_pend[i_m] <= '0;
            if (i_m == BW'(BANDS - 1)) begin
                r_head <= w_new_head;
                if (r_fill != (HW+1)'(HD)) r_fill <= r_fill + 1'b1;
            end
        end else if (i_pend_we) begin
            r_pend[i_pend_band] <= i_pend_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_en && i_tap_ok && w_hist_ok;
            r_v2 <= r_v1;
        end
        r_prod <= r_c * r_h;
        if (i_cmd.clear_acc) r_acc <= '0;
        else if (r_v2) r_acc <= r_acc + ACC_W'(r_prod);
    end

    always_comb begin
        if (i_mode) begin
            n_rnd = (r_acc * ACC_W'(BANDS) + (ACC_W'(1) <<< 23)) >>> 24;
            if (n_rnd > 64'sd32767) n_res = 24'sd32767;
            else if (n_rnd < -64'sd32768) n_res = -24'sd32768;
            else n_res = n_rnd[SAMP_W-1:0];
        end else begin
            n_rnd = (r_acc + (ACC_W'(1) <<< 16)) >>> 17;
            if (n_rnd > 64'sd8388607) n_res = 24'sd8388607;
            else if (n_rnd < -64'sd8388608) n_res = -24'sd8388608;
            else n_res = n_rnd[SAMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (i_cmd.load_out) r_out_v <= 1'b1;
        else if (i_ready) r_out_v <= 1'b0;
        if (i_cmd.load_out) begin
            r_out <= n_res;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.out_full = r_out_v && !i_ready;
    assign o_valid  = r_out_v;
    assign o_sample = r_out;
    assign o_last   = r_out_last;
endmodule
